### rtl/rbg_pkg.sv
// Package for the RMS balance gain stage: widths, codes and the
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbg_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEFF_W    = 24;
  localparam int POWER_W    = 48;
  localparam int GAIN_W     = 24;
  localparam int ACC_W      = 73;
  localparam int PROD_W     = 58;
  localparam int MSQ_W      = 31;
  localparam int CNT_W      = 6;
  localparam int SQREM_W    = 26;

  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(9);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(47);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(23);

  localparam logic [COEFF_W-1:0] POLE_RESET = 24'd16755255;
  localparam logic [GAIN_W-1:0]  GAIN_MAX   = 24'hFFFFFF;

  // Multiplier operations, issued one per cycle and consumed in the next cycle.
  typedef enum logic [3:0] {
    OP_NONE     = 4'd0,
    OP_SQ_SIG   = 4'd1,
    OP_SQ_CMP   = 4'd2,
    OP_C_SIG_LO = 4'd3,
    OP_C_SIG_HI = 4'd4,
    OP_K_SIG    = 4'd5,
    OP_C_CMP_LO = 4'd6,
    OP_C_CMP_HI = 4'd7,
    OP_K_CMP    = 4'd8,
    OP_PROD     = 4'd9
  } op_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQLD = 6'b010000,
    S_SQRT = 6'b100000
  } state_e;

  typedef struct packed {
    logic load_in;
    op_e  mul_op;
    logic pow_update;
    logic prep;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic sig_zero;
    logic ratio_sat;
    logic out_free;
  } sts_t;

  // Order of multiplier operations within one sample. Squares come first
  // so that the pole terms that need them find them registered.
  function automatic op_e op_of_step(input logic [CNT_W-1:0] step);
    op_e op;
    unique case (step)
      CNT_W'(0): op = OP_SQ_SIG;
      CNT_W'(1): op = OP_SQ_CMP;
      CNT_W'(2): op = OP_C_SIG_LO;
      CNT_W'(3): op = OP_C_SIG_HI;
      CNT_W'(4): op = OP_K_SIG;
      CNT_W'(5): op = OP_C_CMP_LO;
      CNT_W'(6): op = OP_C_CMP_HI;
      CNT_W'(7): op = OP_K_CMP;
      CNT_W'(8): op = OP_PROD;
      default:   op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

### rtl/rbg_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on rbg_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none
interface rbg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbg_pkg::SAMPLE_W-1:0] signal_sample;
  logic signed [rbg_pkg::SAMPLE_W-1:0] compare_sample;
  modport source (output valid, output signal_sample, output compare_sample, input ready);
  modport sink   (input valid, input signal_sample, input compare_sample, output ready);
endinterface

interface rbg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbg_pkg::SAMPLE_W-1:0] balanced_sample;
  modport source (output valid, output balanced_sample, input ready);
  modport sink   (input valid, input balanced_sample, output ready);
endinterface
`default_nettype wire

### rtl/rbg_ctrl.sv
// Controller for the RMS balance gain stage: one-hot sequencer that drives
// the datapath through multiply, divide and square-root phases. Uses rbg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbg_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  rbg_pkg::sts_t       sts_i,
  output rbg_pkg::cmd_t       cmd_o
);

  rbg_pkg::state_e            state_q, state_d;
  logic [rbg_pkg::CNT_W-1:0]  cnt_q, cnt_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.mul_op = rbg_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      rbg_pkg::S_IDLE: begin
        // Take a new sample only once the finished result has a free slot.
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.load_in = 1'b1;
          cnt_d   = '0;
          state_d = rbg_pkg::S_MUL;
        end
      end
      rbg_pkg::S_MUL: begin
        cmd_o.mul_op = rbg_pkg::op_of_step(cnt_q);
        if (cnt_q == rbg_pkg::MUL_LAST) begin
          cmd_o.pow_update = 1'b1;
          cmd_o.push       = 1'b1;
          state_d = rbg_pkg::S_PREP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      rbg_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d = '0;
        priority if (sts_i.sig_zero) begin
          state_d = rbg_pkg::S_SQLD;
        end else if (sts_i.ratio_sat) begin
          state_d = rbg_pkg::S_IDLE;
        end else begin
          state_d = rbg_pkg::S_DIV;
        end
      end
      rbg_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == rbg_pkg::DIV_LAST) begin
          state_d = rbg_pkg::S_SQLD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      rbg_pkg::S_SQLD: begin
        cmd_o.sqrt_load = 1'b1;
        cnt_d   = '0;
        state_d = rbg_pkg::S_SQRT;
      end
      rbg_pkg::S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == rbg_pkg::SQRT_LAST) begin
          state_d = rbg_pkg::S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = rbg_pkg::S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbg_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

### rtl/rbg_dp.sv
// Datapath for the RMS balance gain stage: shared multiplier, power
// accumulators, restoring divider, square root and output register. Uses rbg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbg_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [rbg_pkg::COEFF_W-1:0]          cfg_data_i,
  input  wire  signed [rbg_pkg::SAMPLE_W-1:0]  signal_sample_i,
  input  wire  signed [rbg_pkg::SAMPLE_W-1:0]  compare_sample_i,
  input  wire                                  out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [rbg_pkg::SAMPLE_W-1:0]  balanced_sample_o,
  input  rbg_pkg::cmd_t                        cmd_i,
  output rbg_pkg::sts_t                        sts_o
);

  logic [rbg_pkg::COEFF_W-1:0]         pole_q;
  logic signed [rbg_pkg::SAMPLE_W-1:0] sig_q, cmp_q;
  logic [rbg_pkg::POWER_W-1:0]         sig_pow_q, cmp_pow_q;
  logic [rbg_pkg::GAIN_W-1:0]          gain_q;
  logic [rbg_pkg::MSQ_W-1:0]           msq_s_q, msq_c_q;
  logic [rbg_pkg::ACC_W-1:0]           acc_s_q, acc_c_q;
  logic signed [rbg_pkg::PROD_W-1:0]   prod_q;
  rbg_pkg::op_e                        op_q;
  logic                                out_valid_q;
  logic signed [rbg_pkg::SAMPLE_W-1:0] out_data_q;
  logic [rbg_pkg::POWER_W-1:0]         div_rem_q, div_sh_q;
  logic [rbg_pkg::POWER_W-1:0]         sq_v_q;
  logic [rbg_pkg::SQREM_W-1:0]         sq_rem_q;
  logic [rbg_pkg::GAIN_W-1:0]          root_q;

  logic [rbg_pkg::COEFF_W:0]           k;
  logic signed [32:0]                  mul_a, mul_b;
  logic signed [65:0]                  mul_full;
  logic [54:0]                         prod_u;
  logic signed [41:0]                  rnd;
  logic signed [25:0]                  y_wide;
  logic signed [rbg_pkg::SAMPLE_W-1:0] y_sat;
  logic [rbg_pkg::POWER_W:0]           div_rem2, div_q_ext;
  logic                                div_ge;
  logic [rbg_pkg::SQREM_W+1:0]         sq_rem2, sq_trial;
  logic                                sq_ge;

  // Status toward the controller.
  assign sts_o.sig_zero  = (sig_pow_q == '0);
  assign sts_o.ratio_sat = {16'b0, cmp_pow_q} >= {sig_pow_q, 16'b0};
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Shared multiplier operand selection.
  assign k = 25'(1 << rbg_pkg::COEFF_W) - {1'b0, pole_q};
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      rbg_pkg::OP_SQ_SIG: begin
        mul_a = 33'(sig_q);
        mul_b = 33'(sig_q);
      end
      rbg_pkg::OP_SQ_CMP: begin
        mul_a = 33'(cmp_q);
        mul_b = 33'(cmp_q);
      end
      rbg_pkg::OP_C_SIG_LO: begin
        mul_a = {9'b0, pole_q};
        mul_b = {9'b0, sig_pow_q[23:0]};
      end
      rbg_pkg::OP_C_SIG_HI: begin
        mul_a = {9'b0, pole_q};
        mul_b = {9'b0, sig_pow_q[47:24]};
      end
      rbg_pkg::OP_K_SIG: begin
        mul_a = {8'b0, k};
        mul_b = {2'b0, msq_s_q};
      end
      rbg_pkg::OP_C_CMP_LO: begin
        mul_a = {9'b0, pole_q};
        mul_b = {9'b0, cmp_pow_q[23:0]};
      end
      rbg_pkg::OP_C_CMP_HI: begin
        mul_a = {9'b0, pole_q};
        mul_b = {9'b0, cmp_pow_q[47:24]};
      end
      rbg_pkg::OP_K_CMP: begin
        mul_a = {8'b0, k};
        mul_b = {2'b0, msq_c_q};
      end
      rbg_pkg::OP_PROD: begin
        mul_a = 33'(sig_q);
        mul_b = {9'b0, gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;
  assign prod_u   = prod_q[54:0];

  // Output rounding: add one half, floor shift by 16, saturate.
  assign rnd    = prod_q[41:0] + 42'sd32768;
  assign y_wide = rnd[41:16];
  always_comb begin
    priority if (y_wide > 26'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y_wide < -26'sd32768) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_wide[15:0];
    end
  end

  // One restoring division step.
  assign div_rem2  = {div_rem_q, div_sh_q[rbg_pkg::POWER_W-1]};
  assign div_q_ext = {1'b0, sig_pow_q};
  assign div_ge    = div_rem2 >= div_q_ext;

  // One square root digit step.
  assign sq_rem2  = {sq_rem_q, sq_v_q[47:46]};
  assign sq_trial = {2'b0, root_q, 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;

  // Configuration and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q      <= rbg_pkg::POLE_RESET;
      sig_pow_q   <= '0;
      cmp_pow_q   <= '0;
      gain_q      <= '0;
      out_valid_q <= 1'b0;
      op_q        <= rbg_pkg::OP_NONE;
    end else begin
      if (cfg_we_i) begin
        pole_q <= cfg_data_i;
      end
      if (cmd_i.pow_update) begin
        sig_pow_q <= acc_s_q[71:24];
        cmp_pow_q <= acc_c_q[71:24];
      end
      if (cmd_i.prep && !sts_o.sig_zero && sts_o.ratio_sat) begin
        gain_q <= rbg_pkg::GAIN_MAX;
      end else if (cmd_i.sqrt_step) begin
        gain_q <= sq_ge ? {root_q[22:0], 1'b1} : {root_q[22:0], 1'b0};
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      op_q <= cmd_i.mul_op;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[rbg_pkg::PROD_W-1:0];
    if (cmd_i.load_in) begin
      sig_q   <= signal_sample_i;
      cmp_q   <= compare_sample_i;
      acc_s_q <= '0;
      acc_c_q <= '0;
    end
    // Consume last cycle's product.
    unique case (op_q)
      rbg_pkg::OP_SQ_SIG:   msq_s_q <= prod_q[rbg_pkg::MSQ_W-1:0];
      rbg_pkg::OP_SQ_CMP:   msq_c_q <= prod_q[rbg_pkg::MSQ_W-1:0];
      rbg_pkg::OP_C_SIG_LO: acc_s_q <= acc_s_q + rbg_pkg::ACC_W'(prod_u);
      rbg_pkg::OP_C_SIG_HI: acc_s_q <= acc_s_q + (rbg_pkg::ACC_W'(prod_u) << 24);
      rbg_pkg::OP_K_SIG:    acc_s_q <= acc_s_q + (rbg_pkg::ACC_W'(prod_u) << 16);
      rbg_pkg::OP_C_CMP_LO: acc_c_q <= acc_c_q + rbg_pkg::ACC_W'(prod_u);
      rbg_pkg::OP_C_CMP_HI: acc_c_q <= acc_c_q + (rbg_pkg::ACC_W'(prod_u) << 24);
      rbg_pkg::OP_K_CMP:    acc_c_q <= acc_c_q + (rbg_pkg::ACC_W'(prod_u) << 16);
      default: begin
      end
    endcase
    if (cmd_i.push) begin
      out_data_q <= y_sat;
    end
    // Divider: remainder starts from the bits above the quotient range.
    if (cmd_i.prep) begin
      div_rem_q <= {16'b0, cmp_pow_q[47:16]};
      div_sh_q  <= {cmp_pow_q[15:0], 32'b0};
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? 48'(div_rem2 - div_q_ext) : div_rem2[47:0];
      div_sh_q  <= {div_sh_q[46:0], div_ge};
    end
    // Square root operand: scaled compare power alone when signal power is zero.
    if (cmd_i.sqrt_load) begin
      sq_v_q   <= sts_o.sig_zero ? {14'b0, cmp_pow_q[47:14]} : div_sh_q;
      sq_rem_q <= '0;
      root_q   <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_v_q   <= {sq_v_q[45:0], 2'b00};
      sq_rem_q <= sq_ge ? 26'(sq_rem2 - sq_trial) : sq_rem2[25:0];
      root_q   <= sq_ge ? {root_q[22:0], 1'b1} : {root_q[22:0], 1'b0};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign balanced_sample_o = out_data_q;

endmodule
`default_nettype wire

### rtl/rms_balance_gain.sv
// Output: the result is registered at the end of the multiply phase.
// Phases per sample: accept, multiply, setup, divide, load, square root; divide
// is skipped when signal power is zero, and all after setup when the gain saturates.
// The divider and square root work one bit per cycle. A new sample waits until
// the previous one leaves the last phase, and while its result has not been taken.
// Reset: asynchronous, active low; powers and gain clear, pole returns to 10 Hz.
`timescale 1ns / 1ps
`default_nettype none
module rms_balance_gain (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [rbg_pkg::COEFF_W-1:0]   cfg_data_i,
  rbg_in_if.sink                       in_ch,
  rbg_out_if.source                    out_ch
);

  rbg_pkg::cmd_t cmd;
  rbg_pkg::sts_t sts;

  // Sequencer.
  rbg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic.
  rbg_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_data_i        (cfg_data_i),
    .signal_sample_i   (in_ch.signal_sample),
    .compare_sample_i  (in_ch.compare_sample),
    .out_ready_i       (out_ch.ready),
    .out_valid_o       (out_ch.valid),
    .balanced_sample_o (out_ch.balanced_sample),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
`default_nettype wire

### rtl/rbg_checker.sv
// Port-level checker for rms_balance_gain, attached by a bind statement.
// Depends on rbg_pkg for the sample width.
`timescale 1ns / 1ps
`default_nettype none
module rbg_checker (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_i,
  input wire                         out_valid_i,
  input wire                         out_ready_i,
  input wire [rbg_pkg::SAMPLE_W-1:0] balanced_sample_i
);

  // One sample at a time: no transfer directly after another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A result never appears on the cycle after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result too early after input transfer");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(balanced_sample_i))
    else $error("stalled result changed");

endmodule

bind rms_balance_gain rbg_checker u_rbg_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_ch.valid),
  .in_ready_i        (in_ch.ready),
  .out_valid_i       (out_ch.valid),
  .out_ready_i       (out_ch.ready),
  .balanced_sample_i (out_ch.balanced_sample)
);
`default_nettype wire

### test/tb_rms_balance_gain.sv
// Testbench for rms_balance_gain: directed table and poles, then random bursts of
// sample pairs, checked by a bit-accurate predictor. Uses rbg_pkg and rbg_if.
`timescale 1ns / 1ps
module tb_rms_balance_gain;

  localparam int N_RANDOM   = 1030;
  localparam int CYCLE_CAP  = 600000;
  localparam int DRAIN_WAIT = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rbg_pkg::COEFF_W-1:0] cfg_data_i = '0;

  rbg_in_if  in_ch ();
  rbg_out_if out_ch ();

  rms_balance_gain dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  logic [rbg_pkg::COEFF_W-1:0] pole_q;
  logic [rbg_pkg::POWER_W-1:0] sig_pow_q, cmp_pow_q;
  logic [rbg_pkg::GAIN_W-1:0]  gain_q;

  logic signed [rbg_pkg::SAMPLE_W-1:0] balanced_queue[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  // Directed stimulus; has_exp marks rows whose result is obvious.
  typedef struct {
    logic signed [rbg_pkg::SAMPLE_W-1:0] sig;
    logic signed [rbg_pkg::SAMPLE_W-1:0] cmp;
    bit has_exp;
    logic signed [rbg_pkg::SAMPLE_W-1:0] exp;
  } stim_row_t;

  stim_row_t stim_table[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [rbg_pkg::POWER_W-1:0] lowpass(
      input logic [rbg_pkg::POWER_W-1:0] sq,
      input logic [rbg_pkg::POWER_W-1:0] pw,
      input logic [rbg_pkg::COEFF_W:0] c);
    logic [95:0] acc;
    acc = (96'(25'h1000000 - c) * 96'(sq)) + (96'(c) * 96'(pw));
    return acc[rbg_pkg::COEFF_W +: rbg_pkg::POWER_W];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [rbg_pkg::GAIN_W-1:0] gain_for(
      input logic [rbg_pkg::POWER_W-1:0] r,
      input logic [rbg_pkg::POWER_W-1:0] q);
    logic [127:0] quo;
    logic [63:0] g;
    if (q == 0) g = int_sqrt(64'(r >> 14));
    else if (64'(r) >= (64'(q) << 16)) g = 64'hFFFFFF;
    else begin
      quo = (128'(r) << 32) / 128'(q);
      g = int_sqrt(quo[63:0]);
    end
    return (g > 64'hFFFFFF) ? rbg_pkg::GAIN_MAX : g[rbg_pkg::GAIN_W-1:0];
  endfunction

  // Advance the predictor by one sample pair and return the balanced sample.
  function automatic logic signed [rbg_pkg::SAMPLE_W-1:0] balance_step(
      input logic signed [rbg_pkg::SAMPLE_W-1:0] s,
      input logic signed [rbg_pkg::SAMPLE_W-1:0] cs);
    logic [rbg_pkg::COEFF_W:0] c;
    logic [31:0] ms, mc;
    logic signed [63:0] prod, y;
    c = (pole_q > 25'h1000000) ? 25'h1000000 : {1'b0, pole_q};
    ms = (s < 0) ? -32'(s) : 32'(s);
    mc = (cs < 0) ? -32'(cs) : 32'(cs);
    sig_pow_q = lowpass(48'(ms * ms) << 16, sig_pow_q, c);
    cmp_pow_q = lowpass(48'(mc * mc) << 16, cmp_pow_q, c);
    prod = 64'(s) * $signed({40'd0, gain_q});
    y = (prod + 64'sd32768) >>> 16;
    if (y > 64'sd32767) y = 32767;
    if (y < -64'sd32768) y = -32768;
    gain_q = gain_for(cmp_pow_q, sig_pow_q);
    return y[rbg_pkg::SAMPLE_W-1:0];
  endfunction

  // Drive one transfer on the input channel.
  task automatic send_pair(input logic signed [rbg_pkg::SAMPLE_W-1:0] s,
                           input logic signed [rbg_pkg::SAMPLE_W-1:0] cs);
    in_ch.signal_sample <= s;
    in_ch.compare_sample <= cs;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    balanced_queue.push_back(balance_step(s, cs));
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (balanced_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_pole(input logic [rbg_pkg::COEFF_W-1:0] v);
    cfg_data_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pole_q = v;
  endtask

  function automatic logic signed [rbg_pkg::SAMPLE_W-1:0] rand_sample(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  // Receiver: ready in runs; else stalls on a repeating pattern and random holds.
  logic [15:0] stall_pattern = 16'b1011_0011_1000_0110;
  always @(negedge clk_i) begin
    stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
    out_ch.ready <= (cycles % 4000 < 1500) ? 1'b1 :
                    (stall_pattern[0] & ($urandom_range(0, 7) != 0));
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (balanced_queue.size() == 0) begin
        report_mismatch("unexpected result", out_ch.balanced_sample, 0);
      end else begin
        if (out_ch.balanced_sample !== balanced_queue[0])
          report_mismatch("balanced_sample", out_ch.balanced_sample, balanced_queue[0]);
        void'(balanced_queue.pop_front());
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    int burst;
    int mode;
    logic [rbg_pkg::COEFF_W-1:0] poles[5];
    in_ch.valid = 1'b0;
    in_ch.signal_sample = '0;
    in_ch.compare_sample = '0;
    pole_q = rbg_pkg::POLE_RESET;
    sig_pow_q = '0;
    cmp_pow_q = '0;
    gain_q = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // After reset the gain is zero, so the first output is zero.
    stim_table.push_back('{16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh0000});
    stim_table.push_back('{16'sh8000, 16'sh8000, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh0000, 16'sh7FFF, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh0001, 16'sh8000, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh7FFF, 16'sh0001, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh0004, 16'sh7FFF, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0, 16'sh0000});
    stim_table.push_back('{16'shFFFF, 16'sh5555, 1'b0, 16'sh0000});
    stim_table.push_back('{16'sh5555, 16'shAAAA, 1'b0, 16'sh0000});
    foreach (stim_table[i]) begin
      r = stim_table[i];
      send_pair(r.sig, r.cmp);
      if (r.has_exp && balanced_queue[$] !== r.exp)
        report_mismatch("directed row", balanced_queue[$], r.exp);
    end
    drain();

    // A pole of zero tracks each sample, so silence brings the powers straight
    // to zero; zero signal power and full-scale samples are driven as well.
    poles = '{24'hFFFFFF, 24'h000000, 24'h800000, 24'hFF0000, rbg_pkg::POLE_RESET};
    write_pole(24'h000000);
    send_pair(16'sh0000, 16'sh7FFF);
    send_pair(16'sh0100, 16'sh0100);
    send_pair(16'sh8000, 16'sh7FFF);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh0000, 16'sh0000);
    send_pair(16'sh7FFF, 16'sh0000);
    drain();

    // Random part in phases over several pole settings.
    for (int ph = 0; ph < 5; ph++) begin
      write_pole(ph == 3 ? 24'($urandom) : poles[ph]);
      for (int n = 0; n < N_RANDOM / 5; ) begin
        burst = $urandom_range(1, 12);
        mode = $urandom_range(0, 3);
        for (int k = 0; k < burst; k++, n++)
          send_pair(rand_sample(mode), rand_sample($urandom_range(0, 3)));
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 90));
      end
      drain();
    end

    $display("covered %0d results over directed extremes and five pole settings",
             results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/rbg_pkg.sv
rtl/rbg_if.sv
rtl/rbg_ctrl.sv
rtl/rbg_dp.sv
rtl/rms_balance_gain.sv
rtl/rbg_checker.sv
test/tb_rms_balance_gain.sv
